[src/patch_file_name_checker_unit_macros.svh]
`ifndef PATCH_FILE_NAME_CHECKER_UNIT_MACROS_SVH
`define PATCH_FILE_NAME_CHECKER_UNIT_MACROS_SVH

// checked only outside reset
`define PFNC_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// checked on every edge, reset included
`define PFNC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

[src/pfnc_pkg.sv]
`timescale 1ns / 1ps

package pfnc_pkg;

  localparam int MIN_NAME_LEN = 5;
  localparam int TAIL_DEPTH   = 8;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [2:0] {
    RSN_OK,
    RSN_LENGTH,
    RSN_BAD_CHAR,
    RSN_LEAD,
    RSN_TRAIL_DOT,
    RSN_DOT_RUN,
    RSN_EXT,
    RSN_DEVICE
  } reason_t;

  // index 0 is the newest byte
  typedef logic [TAIL_DEPTH-1:0][7:0] tail_t;

  typedef struct packed {
    logic bad_char;
    logic bad_first;
    logic dot_run;
  } name_flags_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
  endfunction

  function automatic logic allowed_byte(input logic [7:0] b);
    return (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z) ||
           (b >= CH_0 && b <= CH_9) || b == CH_DOT || b == CH_DASH || b == CH_UNDER;
  endfunction

endpackage

[src/pfnc_judge.sv]
`timescale 1ns / 1ps

module pfnc_judge import pfnc_pkg::*; #(
  parameter int MAX_NAME_LEN = 64,
  parameter int CNT_W        = 7
) (
  input  logic [CNT_W-1:0] count,
  input  tail_t            tail,
  input  name_flags_t      flags,
  output reason_t          reason
);

  localparam logic [CNT_W-1:0] LEN_MIN = CNT_W'(MIN_NAME_LEN);
  localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_NAME_LEN);
  localparam logic [CNT_W-1:0] LEN_S3  = CNT_W'(7);
  localparam logic [CNT_W-1:0] LEN_S4  = CNT_W'(8);

  logic ext_ok;
  logic stem3_dev;
  logic stem4_dev;
  logic [23:0] stem3;
  logic [23:0] stem4;

  always_comb begin
    stem3  = {tail[6], tail[5], tail[4]};
    stem4  = {tail[7], tail[6], tail[5]};
    ext_ok = {tail[3], tail[2], tail[1], tail[0]} == ".mpq";
    stem3_dev = (count == LEN_S3) &&
                (stem3 == "con" || stem3 == "prn" || stem3 == "aux" || stem3 == "nul");
    stem4_dev = (count == LEN_S4) && tail[4] >= CH_1 && tail[4] <= CH_9 &&
                (stem4 == "com" || stem4 == "lpt");
  end

  always_comb begin
    priority if (count < LEN_MIN || count > LEN_MAX) begin
      reason = RSN_LENGTH;
    end else if (flags.bad_char) begin
      reason = RSN_BAD_CHAR;
    end else if (flags.bad_first) begin
      reason = RSN_LEAD;
    end else if (tail[0] == CH_DOT) begin
      reason = RSN_TRAIL_DOT;
    end else if (flags.dot_run) begin
      reason = RSN_DOT_RUN;
    end else if (!ext_ok) begin
      reason = RSN_EXT;
    end else if (stem3_dev || stem4_dev) begin
      reason = RSN_DEVICE;
    end else begin
      reason = RSN_OK;
    end
  end

endmodule

[src/patch_file_name_checker_unit.sv]
`timescale 1ns / 1ps
// channel  dir  tdata                          tlast      tuser
// s_       in   [7:0] name_byte                last_byte  -
// m_       out  [0] accepted, [3:1] reason     -          -
//
// One byte per cycle sustained while no final byte waits on a held verdict; a verdict
// is registered after the final byte is taken (input register, then result register).
// rst is synchronous and clears the running name and both valid flags.
// A waiting verdict holds only a final byte in the input register; other bytes keep flowing.
`include "patch_file_name_checker_unit_macros.svh"

module patch_file_name_checker_unit import pfnc_pkg::*; #(
  parameter int MAX_NAME_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] name_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] accepted, [3:1] reason, [7:4] zero
);

  localparam int CNT_W = $clog2(MAX_NAME_LEN + 2);
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_NAME_LEN + 1);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_last;
  logic             advance;

  logic [CNT_W-1:0] byte_count;
  logic             prev_dot;
  name_flags_t      flags;
  tail_t            tail;

  logic [CNT_W-1:0] byte_count_next;
  logic             is_dot;
  name_flags_t      flags_next;
  tail_t            tail_next;
  reason_t          verdict;

  logic             out_valid;
  reason_t          out_reason;

  assign advance  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_comb begin
    is_dot              = in_byte == CH_DOT;
    flags_next.bad_first = (byte_count == '0) ? (is_dot || in_byte == CH_DASH)
                                              : flags.bad_first;
    flags_next.bad_char  = flags.bad_char || !allowed_byte(in_byte);
    flags_next.dot_run   = flags.dot_run || (is_dot && prev_dot);
    tail_next            = {tail[TAIL_DEPTH-2:0], fold_case(in_byte)};
    byte_count_next      = (byte_count < CNT_SAT) ? byte_count + CNT_W'(1) : byte_count;
  end

  pfnc_judge #(
    .MAX_NAME_LEN(MAX_NAME_LEN),
    .CNT_W       (CNT_W)
  ) u_judge (
    .count  (byte_count_next),
    .tail   (tail_next),
    .flags  (flags_next),
    .reason (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      prev_dot   <= 1'b0;
      flags      <= '0;
      tail       <= '0;
    end else if (advance) begin
      if (in_last) begin
        byte_count <= '0;
        prev_dot   <= 1'b0;
        flags      <= '0;
        tail       <= '0;
      end else begin
        byte_count <= byte_count_next;
        prev_dot   <= is_dot;
        flags      <= flags_next;
        tail       <= tail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && in_last) begin
      out_reason <= verdict;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_reason, out_reason == RSN_OK};

  `PFNC_ASSERT(a_acc_matches_reason, clk, rst,
    m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == RSN_OK)),
    "accepted disagrees with reason")
  `PFNC_ASSERT(a_mid_byte_no_result, clk, rst,
    (in_valid && !in_last && (!out_valid || m_tready)) |=> !out_valid,
    "result without final byte")
  `PFNC_ASSERT(a_clear_after_verdict, clk, rst,
    (advance && in_last) |=> (byte_count == '0 && flags == '0 && !prev_dot),
    "state not cleared after verdict")
  `PFNC_ASSERT(a_count_bounded, clk, rst, byte_count <= CNT_SAT,
    "byte count past saturation")
  `PFNC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!out_valid && !in_valid),
    "valid set after reset")

endmodule

[dv/patch_file_name_checker_unit_test.sv]
`timescale 1ns / 1ps

module patch_file_name_checker_unit_test;
  import pfnc_pkg::*;

  localparam int NAME_MAX = 64;
  localparam string LEGAL_POOL =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._-";

  typedef struct packed {
    logic    accepted;
    reason_t reason;
  } verdict_t;

  class verdict_predictor;
    int unsigned name_len;
    logic        char_bad;
    logic        lead_bad;
    logic        last_dot;
    logic        run_bad;
    logic [7:0]  tail[TAIL_DEPTH];
    verdict_t    pending_verdicts[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
      clear();
    endfunction

    function void clear();
      name_len = 0;
      char_bad = 1'b0;
      lead_bad = 1'b0;
      last_dot = 1'b0;
      run_bad  = 1'b0;
      for (int i = 0; i < TAIL_DEPTH; i++) tail[i] = 8'h00;
    endfunction

    // k indexes the tail, 0 = newest; text is matched oldest first
    function bit match_tail(int k, string text);
      for (int i = 0; i < text.len(); i++) begin
        if (tail[(k - i) & (TAIL_DEPTH - 1)] != 8'(text[i])) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      verdict_t   v;
      logic       is_dot;
      logic       legal;
      logic       device;
      int         stem_len;
      is_dot = (b == CH_DOT);
      legal = (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z) ||
              (b >= CH_0 && b <= CH_9) || is_dot || b == CH_DASH || b == CH_UNDER;
      if (name_len == 0) lead_bad = is_dot || b == CH_DASH;
      if (!legal) char_bad = 1'b1;
      if (is_dot && last_dot) run_bad = 1'b1;
      last_dot = is_dot;
      for (int i = TAIL_DEPTH - 1; i > 0; i--) tail[i] = tail[i-1];
      tail[0] = (b >= CH_UP_A && b <= CH_UP_Z) ? b | CASE_OFS : b;
      if (name_len < NAME_MAX + 1) name_len++;
      if (!last) return;

      stem_len = int'(name_len) - 4;
      device = 1'b0;
      if (stem_len == 3)
        device = match_tail(6, "con") || match_tail(6, "prn") ||
                 match_tail(6, "aux") || match_tail(6, "nul");
      else if (stem_len == 4 && tail[4] >= CH_1 && tail[4] <= CH_9)
        device = match_tail(7, "com") || match_tail(7, "lpt");

      if (name_len < MIN_NAME_LEN || name_len > NAME_MAX) v.reason = RSN_LENGTH;
      else if (char_bad)                                  v.reason = RSN_BAD_CHAR;
      else if (lead_bad)                                  v.reason = RSN_LEAD;
      else if (tail[0] == CH_DOT)                         v.reason = RSN_TRAIL_DOT;
      else if (run_bad)                                   v.reason = RSN_DOT_RUN;
      else if (!match_tail(3, ".mpq"))                    v.reason = RSN_EXT;
      else if (device)                                    v.reason = RSN_DEVICE;
      else                                                v.reason = RSN_OK;
      v.accepted = (v.reason == RSN_OK);
      pending_verdicts.insert(pending_verdicts.size(), v);
      clear();
    endfunction

    function void check_verdict(logic [7:0] word);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("verdict 0x%02h with no request pending", word);
        mismatch_count++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (word[0] !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, word[0]);
        mismatch_count++;
      end
      if (word[3:1] !== want.reason) begin
        $error("reason: expected %0d, got %0d", want.reason, word[3:1]);
        mismatch_count++;
      end
      if (word[7:4] !== 4'h0) begin
        $error("pad: expected 0, got 0x%01h", word[7:4]);
        mismatch_count++;
      end
    endfunction
  endclass

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;   // [7:0] name_byte
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;            // [0] accepted, [3:1] reason, [7:4] zero

  verdict_predictor board = new();
  logic [7:0]  name_buf[$];
  bit          no_idle = 1'b0;
  int unsigned bytes_sent = 0;

  patch_file_name_checker_unit #(
    .MAX_NAME_LEN(NAME_MAX)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // entered and left just after a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    board.take_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_buf();
    for (int i = 0; i < name_buf.size(); i++)
      send_byte(name_buf[i], i == name_buf.size() - 1);
  endtask

  function automatic logic [7:0] mix_case(logic [7:0] c);
    if (c >= CH_LO_A && c <= CH_LO_Z && $urandom_range(0, 1)) return c - CASE_OFS;
    return c;
  endfunction

  function automatic void push_text(string text, bit mix);
    for (int i = 0; i < text.len(); i++)
      name_buf.insert(name_buf.size(), mix ? mix_case(8'(text[i])) : 8'(text[i]));
  endfunction

  function automatic logic [7:0] pick_legal();
    return 8'(LEGAL_POOL[$urandom_range(0, LEGAL_POOL.len() - 1)]);
  endfunction

  task automatic send_name(string text);
    name_buf.delete();
    push_text(text, 1'b0);
    send_buf();
  endtask

  always begin
    int gap;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_verdict(m_tdata);
      @(negedge clk);
    end
  end

  initial begin
    string       devs[4];
    int          kind;
    int          len;
    int          pos;
    devs = '{"con", "prn", "aux", "nul"};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_name("a");
    send_name("abcd");
    send_name("a.mpq");
    send_name("ab.mpq");
    send_name("Zz9_-.MpQ");
    name_buf.delete();
    repeat (60) name_buf.insert(name_buf.size(), "x");
    push_text(".mpq", 1'b0);
    send_buf();
    name_buf.push_front("y");
    send_buf();
    // long enough that an unsaturated 7-bit count would wrap
    repeat (70) name_buf.push_front("z");
    send_buf();
    name_buf.delete();
    push_text("ab", 1'b0);
    name_buf.insert(name_buf.size(), 8'h80);
    name_buf.insert(name_buf.size(), 8'hFF);
    name_buf.insert(name_buf.size(), 8'h00);
    name_buf.insert(name_buf.size(), 8'h7F);
    push_text(".mpq", 1'b0);
    send_buf();
    send_name("ab cd.mpq");
    send_name(".abc.mpq");
    send_name("-abc.mpq");
    send_name("abcde.");
    send_name("ab..c.mpq");
    send_name("abc.mpx");
    send_name("CON.mpq");
    send_name("prn.MPQ");
    send_name("Aux.mpq");
    send_name("nul.mpq");
    send_name("com1.mpq");
    send_name("LPT9.mpq");
    send_name("com0.mpq");
    send_name("xcon.mpq");

    while (bytes_sent < 700) begin
      no_idle = ($urandom_range(0, 4) == 0);
      name_buf.delete();
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 62) : $urandom_range(1, 12);
        repeat (len) name_buf.insert(name_buf.size(), mix_case(pick_legal()));
        push_text(".mpq", 1'b1);
        case ($urandom_range(0, 7))
          0: name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(0, 255));
          1: name_buf[0] = $urandom_range(0, 1) ? CH_DOT : CH_DASH;
          2: name_buf.insert(name_buf.size(), CH_DOT);
          3: begin
            pos = $urandom_range(0, name_buf.size() - 1);
            name_buf.insert(pos, CH_DOT);
            name_buf.insert(pos, CH_DOT);
          end
          4: name_buf[name_buf.size() - 1 - $urandom_range(0, 3)] = pick_legal();
          default: ;
        endcase
      end else if (kind < 15) begin
        if ($urandom_range(0, 1)) begin
          push_text(devs[$urandom_range(0, 3)], 1'b1);
        end else begin
          push_text($urandom_range(0, 1) ? "com" : "lpt", 1'b1);
          name_buf.insert(name_buf.size(), CH_0 + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0)
          name_buf.insert($urandom_range(0, name_buf.size()), pick_legal());
        push_text(".mpq", 1'b1);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 90) : $urandom_range(1, 12);
        repeat (len)
          name_buf.insert(name_buf.size(),
                          $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_legal());
      end
      send_buf();
    end
    s_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
